FILE: rtl/core/dotq_pkg.sv
`default_nettype none
package dotq_pkg;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int TIME_W   = 63;
  localparam int OCC_W    = 5;

  localparam int QUEUE_DEPTH_DEF = 16;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_SCHEDULE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POLL       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP_NOW   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STOP_DRAIN = 2'd3;

  typedef enum logic [1:0] {
    OP_SCHEDULE,
    OP_POLL,
    OP_STOP_NOW,
    OP_STOP_DRAIN
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   when_ms;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/dotq_if.sv
`default_nettype none
interface dotq_req_if;
  logic                          valid;
  logic                          ready;
  logic [dotq_pkg::KIND_W-1:0]   kind;
  logic [dotq_pkg::HANDLE_W-1:0] task_handle;
  logic [dotq_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, kind, task_handle, time_ms, input ready);
  modport sink   (input valid, kind, task_handle, time_ms, output ready);
endinterface

interface dotq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          dispatched;
  logic [dotq_pkg::HANDLE_W-1:0] dispatched_handle;
  logic [dotq_pkg::OCC_W-1:0]    occupancy;
  logic                          halted;
  logic                          dropped;

  modport source (output valid, dispatched, dispatched_handle, occupancy, halted, dropped,
                  input ready);
  modport sink   (input valid, dispatched, dispatched_handle, occupancy, halted, dropped,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/deadline_ordered_task_queue_top.sv
`default_nettype none
// Deadline-ordered task queue. Each request beat is a schedule (insert a
// handle with a deadline), a poll (current time; pop the earliest task if it
// is due and dispatch is not halted), a stop-now or a stop-when-drained, and
// each one yields exactly one response beat carrying the dispatch result, the
// occupancy after the beat, the halted state and a dropped flag for a
// schedule that met a full table. Tasks with equal deadlines leave in
// arrival order. The front decodes beats into a two-entry command queue; the
// back holds the sorted table as a shift register with one deadline compare
// per entry, so an insert or a pop shifts all entries in parallel and one
// beat is taken per clock while the output register is free or drains. A
// request passes the front queue and then the output register before its
// response is valid. While a response waits in the output register the back
// holds, and the front queue takes up to two more beats before it stalls
// the input. The table needs no clearing after reset: only entries below
// the count are ever read.
module deadline_ordered_task_queue_top #(
  parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dotq_req_if.sink   req,
  dotq_rsp_if.source rsp
);
  import dotq_pkg::*;

  // command handed from front to back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  // decode and buffer request beats
  dotq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  // sorted table, stop flags and response register
  dotq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

FILE: rtl/core/dotq_front.sv
`default_nettype none
module dotq_front (
  input  wire logic         clk,
  input  wire logic         rst,
  dotq_req_if.sink          req,
  output dotq_pkg::cmd_t    cmd,
  output logic              cmd_valid,
  input  wire logic         cmd_take
);
  import dotq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // classify the incoming beat
  always_comb begin
    dec.handle  = req.task_handle;
    dec.when_ms = req.time_ms;
    unique case (req.kind)
      KIND_SCHEDULE:   dec.op = OP_SCHEDULE;
      KIND_POLL:       dec.op = OP_POLL;
      KIND_STOP_NOW:   dec.op = OP_STOP_NOW;
      KIND_STOP_DRAIN: dec.op = OP_STOP_DRAIN;
      default:         dec.op = OP_STOP_DRAIN;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dotq_back.sv
`default_nettype none
module dotq_back #(
  parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dotq_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_take,
  dotq_rsp_if.source          rsp
);
  import dotq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_W-1:0]   dl  [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] hd  [QUEUE_DEPTH];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                stop_now;
  logic                stop_now_next;
  logic                stop_drain;
  logic                stop_drain_next;

  logic                out_valid;
  logic                out_disp;
  logic [HANDLE_W-1:0] out_handle;
  logic [OCC_W-1:0]    out_occ;
  logic                out_halted;
  logic                out_dropped;

  logic                step;
  logic                halted_cur;
  logic                full;
  logic                due;
  logic                do_ins;
  logic                do_pop;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] shift_w;
  logic [QUEUE_DEPTH-1:0] place_w;

  assign step     = cmd_valid && (!out_valid || rsp.ready);
  assign cmd_take = step;

  assign halted_cur = stop_now || (stop_drain && (count == '0));
  assign full       = (count == CW'(QUEUE_DEPTH));
  assign due        = !halted_cur && (count != '0) && (dl[0] <= cmd.when_ms);
  assign do_ins     = (cmd.op == OP_SCHEDULE) && !full;
  assign do_pop     = (cmd.op == OP_POLL) && due;

  // parallel compare: entries later than the new deadline move up one place
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
    assign gt[i] = (CW'(i) < count) && (dl[i] > cmd.when_ms);
    if (i == 0) begin : g_head
      assign shift_w[i] = 1'b0;
    end else begin : g_body
      assign shift_w[i] = gt[i-1];
    end
    assign place_w[i] = !shift_w[i] && (gt[i] || (CW'(i) == count));
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (step && do_ins) begin
        if (shift_w[i]) begin
          if (i > 0) begin
            dl[i] <= dl[(i > 0) ? i - 1 : 0];
            hd[i] <= hd[(i > 0) ? i - 1 : 0];
          end
        end else if (place_w[i]) begin
          dl[i] <= cmd.when_ms;
          hd[i] <= cmd.handle;
        end
      end else if (step && do_pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          dl[i] <= dl[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          hd[i] <= hd[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_next      = count;
    stop_now_next   = stop_now;
    stop_drain_next = stop_drain;
    unique case (cmd.op)
      OP_SCHEDULE:   if (do_ins) count_next = count + CW'(1);
      OP_POLL:       if (do_pop) count_next = count - CW'(1);
      OP_STOP_NOW:   stop_now_next = 1'b1;
      OP_STOP_DRAIN: stop_drain_next = 1'b1;
      default:       count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      stop_now   <= 1'b0;
      stop_drain <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (step) begin
        count      <= count_next;
        stop_now   <= stop_now_next;
        stop_drain <= stop_drain_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_disp    <= do_pop;
      out_handle  <= do_pop ? hd[0] : '0;
      out_occ     <= OCC_W'(count_next);
      out_halted  <= stop_now_next || (stop_drain_next && (count_next == '0));
      out_dropped <= (cmd.op == OP_SCHEDULE) && full;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.dispatched        = out_disp;
  assign rsp.dispatched_handle = out_handle;
  assign rsp.occupancy         = out_occ;
  assign rsp.halted            = out_halted;
  assign rsp.dropped           = out_dropped;

endmodule
`default_nettype wire

FILE: bench/dotq_checker.sv
`default_nettype none
// Watches both channels, keeps a sorted copy of the task table and compares
// every response beat with the oldest prediction still waiting.
module dotq_checker #(
  parameter int DEPTH = dotq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  dotq_req_if       req,
  dotq_rsp_if       rsp,
  output int        mismatches,
  output int        outstanding
);
  import dotq_pkg::*;

  typedef struct packed {
    logic                dispatched;
    logic [HANDLE_W-1:0] handle;
    logic [OCC_W-1:0]    occupancy;
    logic                halted;
    logic                dropped;
  } response_t;

  logic [TIME_W-1:0]   deadline_tbl [DEPTH];
  logic [HANDLE_W-1:0] handle_tbl   [DEPTH];
  int                  task_count;
  bit                  stop_now_seen;
  bit                  stop_drain_seen;
  response_t           awaited_responses [$];
  int                  mismatch_count;

  function automatic bit dispatch_halted();
    return stop_now_seen || (stop_drain_seen && task_count == 0);
  endfunction

  // Insert after every task with an equal or earlier deadline.
  task automatic insert_task(input logic [HANDLE_W-1:0] handle,
                             input logic [TIME_W-1:0] when_ms, output bit full);
    int pos;
    full = (task_count >= DEPTH);
    if (!full) begin
      pos = 0;
      while (pos < task_count && deadline_tbl[pos] <= when_ms) pos++;
      for (int i = task_count; i > pos; i--) begin
        deadline_tbl[i] = deadline_tbl[i-1];
        handle_tbl[i]   = handle_tbl[i-1];
      end
      deadline_tbl[pos] = when_ms;
      handle_tbl[pos]   = handle;
      task_count++;
    end
  endtask

  task automatic take_earliest(output logic [HANDLE_W-1:0] handle);
    handle = handle_tbl[0];
    for (int i = 1; i < task_count; i++) begin
      deadline_tbl[i-1] = deadline_tbl[i];
      handle_tbl[i-1]   = handle_tbl[i];
    end
    task_count--;
  endtask

  task automatic predict_response(input logic [KIND_W-1:0] kind,
                                  input logic [HANDLE_W-1:0] handle,
                                  input logic [TIME_W-1:0] when_ms,
                                  output response_t resp);
    bit                  full;
    logic [HANDLE_W-1:0] taken;
    resp = '0;
    case (kind)
      KIND_SCHEDULE: begin
        insert_task(handle, when_ms, full);
        resp.dropped = full;
      end
      KIND_POLL: begin
        if (!dispatch_halted() && task_count > 0 && deadline_tbl[0] <= when_ms) begin
          take_earliest(taken);
          resp.dispatched = 1'b1;
          resp.handle     = taken;
        end
      end
      KIND_STOP_NOW: stop_now_seen = 1'b1;
      default:       stop_drain_seen = 1'b1;
    endcase
    resp.occupancy = task_count[OCC_W-1:0];
    resp.halted    = dispatch_halted();
  endtask

  always @(posedge clk) begin : watch
    response_t want;
    response_t got;
    if (rst) begin
      task_count      = 0;
      stop_now_seen   = 1'b0;
      stop_drain_seen = 1'b0;
      mismatch_count  = 0;
      awaited_responses.delete();
    end else begin
      // check the response first: it can never belong to a beat taken now
      if (rsp.valid && rsp.ready) begin
        got.dispatched = rsp.dispatched;
        got.handle     = rsp.dispatched_handle;
        got.occupancy  = rsp.occupancy;
        got.halted     = rsp.halted;
        got.dropped    = rsp.dropped;
        if (awaited_responses.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected response: expected none", $time);
          $display("%0t:   actual   disp=%0b handle=%h occ=%0d halted=%0b dropped=%0b",
                   $time, got.dispatched, got.handle, got.occupancy, got.halted,
                   got.dropped);
        end else begin
          want = awaited_responses.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: response mismatch: expected disp=%0b handle=%h occ=%0d",
                     $time, want.dispatched, want.handle, want.occupancy);
            $display("%0t:   expected halted=%0b dropped=%0b",
                     $time, want.halted, want.dropped);
            $display("%0t:   actual   disp=%0b handle=%h occ=%0d halted=%0b dropped=%0b",
                     $time, got.dispatched, got.handle, got.occupancy, got.halted,
                     got.dropped);
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_response(req.kind, req.task_handle, req.time_ms, want);
        awaited_responses.push_back(want);
      end
    end
    mismatches  <= mismatch_count;
    outstanding <= awaited_responses.size();
  end
endmodule
`default_nettype wire

FILE: bench/tb_deadline_ordered_task_queue_top.sv
`default_nettype none
module tb_deadline_ordered_task_queue_top;
  import dotq_pkg::*;

  localparam int              HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int              WATCHDOG_LIMIT = 3000;  // cycles without any beat
  localparam int              TAIL_CYCLES    = 10;
  localparam int              RANDOM_TARGET  = 1490;
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

  logic clk;
  logic rst;

  dotq_req_if req_ch ();
  dotq_rsp_if rsp_ch ();

  int mismatches;
  int outstanding;

  deadline_ordered_task_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dotq_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Sender-side bookkeeping: the running clock used for deadlines and polls.
  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] last_deadline;
  int                items_sent;
  bit                hold_off;

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Offer one beat from the falling edge and hold it until it is taken.
  // Valid stays high on return so back-to-back beats need no re-raise.
  task automatic send_beat(input logic [KIND_W-1:0] kind,
                           input logic [HANDLE_W-1:0] handle,
                           input logic [TIME_W-1:0] when_ms);
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.task_handle <= handle;
    req_ch.time_ms     <= when_ms;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Drop valid for a number of cycles, with junk on the payload.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_W'($urandom());
      req_ch.task_handle <= $urandom();
      req_ch.time_ms     <= rand_time();
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted response has come back.
  task automatic pause_until_drained();
    idle_gap(1);
    while (outstanding != 0) @(negedge clk);
  endtask

  // One random beat. Deadlines sit mostly just ahead of the running clock so
  // that polls find due tasks; a few land anywhere in the 63-bit range and
  // only leave on a poll far in the future.
  task automatic send_random(input bit schedule_heavy);
    int                roll;
    int                pick;
    logic [TIME_W-1:0] when_ms;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < (schedule_heavy ? 75 : 35)) begin
      if (pick == 0)      when_ms = rand_time();
      else if (pick == 1) when_ms = last_deadline;    // equal deadline, arrival order
      else                when_ms = clock_ms + $urandom_range(0, 40);
      last_deadline = when_ms;
      send_beat(KIND_SCHEDULE, $urandom(), when_ms);
    end else if (roll < 98) begin
      if (pick == 0)      when_ms = TIME_MAX;
      else if (pick == 1) when_ms = rand_time();
      else begin
        clock_ms = clock_ms + $urandom_range(0, 6);
        when_ms  = clock_ms;
      end
      send_beat(KIND_POLL, $urandom(), when_ms);
    end else begin
      // repeated drain stop: no further effect
      send_beat(KIND_STOP_DRAIN, $urandom(), rand_time());
    end
  endtask

  // Receiver: switch between stall patterns at the end of each random-length phase, and
  // honour a long hold-off when the sender asks for one.
  initial begin : receiver
    int stall_mode;
    int phase_left;
    int cycle_n;
    stall_mode   = 0;
    phase_left   = 0;
    cycle_n      = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle_n++;
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (stall_mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (cycle_n % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int  burst_len;
    bit  schedule_heavy;
    bit  hold_done;
    bit  pause_done;
    rst                = 1'b1;
    hold_off           = 1'b0;
    hold_done          = 1'b0;
    pause_done         = 1'b0;
    items_sent         = 0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_SCHEDULE;
    req_ch.task_handle = '0;
    req_ch.time_ms     = '0;
    clock_ms           = TIME_W'($urandom());
    last_deadline      = clock_ms;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats: empty-table poll, field extremes, equal deadlines,
    // poll just before a deadline, the drain stop on an empty table.
    send_beat(KIND_POLL,     $urandom(),     '0);
    send_beat(KIND_SCHEDULE, 32'h0000_0000,  '0);
    send_beat(KIND_SCHEDULE, 32'hFFFF_FFFF,  TIME_MAX);
    send_beat(KIND_SCHEDULE, 32'h0000_00A1,  TIME_W'(100));
    send_beat(KIND_SCHEDULE, 32'h0000_00B2,  TIME_W'(100));
    send_beat(KIND_SCHEDULE, 32'h0000_00C3,  TIME_W'(50));
    send_beat(KIND_POLL,     $urandom(),     '0);
    send_beat(KIND_POLL,     $urandom(),     TIME_W'(49));
    send_beat(KIND_POLL,     $urandom(),     TIME_W'(50));
    send_beat(KIND_POLL,     $urandom(),     TIME_W'(100));
    send_beat(KIND_POLL,     $urandom(),     TIME_W'(100));
    send_beat(KIND_POLL,     $urandom(),     TIME_MAX - 1);
    send_beat(KIND_POLL,     $urandom(),     TIME_MAX);
    send_beat(KIND_STOP_DRAIN, $urandom(),   rand_time());
    send_beat(KIND_POLL,     $urandom(),     TIME_MAX);
    // alternating bit patterns; a pending task lifts the drain halt
    send_beat(KIND_SCHEDULE, 32'hAA55_AA55,  TIME_W'({(TIME_W+1)/2{2'b01}}));
    send_beat(KIND_SCHEDULE, 32'h55AA_55AA,  TIME_W'({(TIME_W+1)/2{2'b10}}));
    send_beat(KIND_POLL,     $urandom(),     TIME_MAX);
    send_beat(KIND_POLL,     $urandom(),     TIME_MAX);
    send_beat(KIND_STOP_DRAIN, $urandom(),   rand_time());
    idle_gap($urandom_range(1, 8));

    // Overfill the table straight away so the full case is hit early.
    repeat (18) send_beat(KIND_SCHEDULE, $urandom(), clock_ms + $urandom_range(0, 20));

    // Random bursts. Stop-now is held back to the close: it can never be
    // cleared without a reset, so it would end dispatch for the whole run.
    while (items_sent < RANDOM_TARGET) begin
      burst_len      = $urandom_range(1, 24);
      schedule_heavy = ($urandom_range(0, 2) == 0);
      repeat (burst_len) send_random(schedule_heavy);

      if (!hold_done && items_sent >= 500) begin
        // hold the receiver off and keep offering until the input backs up
        hold_done = 1'b1;
        hold_off  = 1'b1;
        repeat (20) send_random(1'b1);
      end
      if (!pause_done && items_sent >= 1000) begin
        pause_done = 1'b1;
        pause_until_drained();
      end

      case ($urandom_range(0, 9))
        0, 1, 2: ;                                    // no gap
        3:       idle_gap($urandom_range(8, 20));
        default: idle_gap($urandom_range(1, 4));
      endcase
    end

    // Close: stop at once, then show that polls no longer dispatch while
    // schedules still go in, up to a full table, and that repeats change nothing.
    pause_until_drained();
    send_beat(KIND_STOP_NOW, $urandom(), rand_time());
    send_beat(KIND_POLL,     $urandom(), TIME_MAX);
    repeat (17) send_beat(KIND_SCHEDULE, $urandom(), clock_ms + $urandom_range(0, 20));
    send_beat(KIND_POLL,       $urandom(), TIME_MAX);
    send_beat(KIND_STOP_NOW,   $urandom(), rand_time());
    send_beat(KIND_STOP_DRAIN, $urandom(), rand_time());
    repeat (4) send_beat(KIND_POLL, $urandom(), rand_time());
    idle_gap(1);

    // Let every response come home, then allow for the pipeline tail.
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/dotq_pkg.sv
rtl/core/dotq_if.sv
rtl/core/dotq_front.sv
rtl/core/dotq_back.sv
rtl/core/deadline_ordered_task_queue_top.sv
bench/dotq_checker.sv
bench/tb_deadline_ordered_task_queue_top.sv
